// File: src/vdp_pkg.sv
package vdp_pkg;

	localparam int ENTRY_COUNT = 256;
	localparam int LEVEL_BITS  = 6;
	localparam int ENTRY_BITS  = 3 * LEVEL_BITS;
	localparam int PEND_BITS   = 2 * LEVEL_BITS;
	localparam int ADDR_BITS   = $clog2(ENTRY_COUNT);
	localparam int OUT_BITS    = 6;
	localparam logic [7:0] MASK_RESET = 8'hFF;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PORT_MASK = 2'd0,
		PORT_RIDX = 2'd1,
		PORT_WIDX = 2'd2,
		PORT_DATA = 2'd3
	} port_t;

	typedef enum logic [1:0] {
		PH_RED   = 2'd0,
		PH_GREEN = 2'd1,
		PH_BLUE  = 2'd2
	} phase_t;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_FETCH = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic emit;
	} ctl_t;

	function automatic logic [LEVEL_BITS-1:0] entry_level(
		input logic [ENTRY_BITS-1:0] entry,
		input phase_t                ph
	);
		logic [LEVEL_BITS-1:0] lvl;
		case (ph)
			PH_GREEN: lvl = entry[PEND_BITS-1 -: LEVEL_BITS];
			PH_BLUE:  lvl = entry[LEVEL_BITS-1:0];
			default:  lvl = entry[ENTRY_BITS-1 -: LEVEL_BITS];
		endcase
		return lvl;
	endfunction

endpackage

// File: src/vdp_ram.sv
module vdp_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/vdp_ctrl.sv
module vdp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output vdp_pkg::ctl_t ctl
);
	import vdp_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   ready;

	assign ready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid && ready) state_d = ST_FETCH;
			ST_FETCH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = ready;
		m_tvalid = out_valid_q;
		ctl.load = s_tvalid && ready;
		ctl.emit = (state_q == ST_FETCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FETCH) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/vdp_datapath.sv
module vdp_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  vdp_pkg::ctl_t                 ctl,
	input  logic [1:0]                    command,
	input  logic [1:0]                    port,
	input  logic [7:0]                    data,
	output logic [7:0]                    read_data,
	output logic [vdp_pkg::OUT_BITS-1:0]  red,
	output logic [vdp_pkg::OUT_BITS-1:0]  green,
	output logic [vdp_pkg::OUT_BITS-1:0]  blue
);
	import vdp_pkg::*;

	cmd_t  cmd_in;
	port_t port_in;

	logic [7:0]           wr_ptr_q, rd_ptr_q, mask_q;
	phase_t               wr_ph_q, rd_ph_q;
	logic [PEND_BITS-1:0] pend_q;

	cmd_t   cmd_s1;
	port_t  port_s1;
	phase_t ph_s1;
	logic [7:0] pre_s1;

	logic [LEVEL_BITS-1:0] level;
	logic [7:0]            pix_idx;
	logic                  ram_we;
	logic [ADDR_BITS-1:0]  ram_raddr;
	logic [ENTRY_BITS-1:0] ram_rdata;
	phase_t                rd_ph_eff;

	assign cmd_in    = cmd_t'(command);
	assign port_in   = port_t'(port);
	assign level     = data[LEVEL_BITS-1:0];
	assign pix_idx   = data & mask_q;
	assign rd_ph_eff = (rd_ph_q == PH_GREEN || rd_ph_q == PH_BLUE) ? rd_ph_q : PH_RED;
	assign ram_we    = ctl.load && (cmd_in == CMD_WRITE) && (port_in == PORT_DATA)
		&& (wr_ph_q == PH_BLUE);
	assign ram_raddr = (cmd_in == CMD_LOOKUP) ? pix_idx[ADDR_BITS-1:0]
		: rd_ptr_q[ADDR_BITS-1:0];

	vdp_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(ENTRY_COUNT)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_ptr_q[ADDR_BITS-1:0]),
		.wdata({pend_q, level}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			wr_ph_q  <= PH_RED;
			rd_ph_q  <= PH_RED;
			pend_q   <= '0;
			mask_q   <= MASK_RESET;
		end else if (ctl.load) begin
			case (cmd_in)
				CMD_WRITE: begin
					unique case (port_in)
						PORT_MASK: mask_q <= data;
						PORT_RIDX: begin
							rd_ptr_q <= data;
							rd_ph_q  <= PH_RED;
						end
						PORT_WIDX: begin
							wr_ptr_q <= data;
							wr_ph_q  <= PH_RED;
						end
						default: begin
							case (wr_ph_q)
								PH_GREEN: begin
									pend_q  <= {pend_q[LEVEL_BITS-1:0], level};
									wr_ph_q <= PH_BLUE;
								end
								PH_BLUE: begin
									wr_ptr_q <= wr_ptr_q + 8'd1;
									wr_ph_q  <= PH_RED;
								end
								default: begin
									pend_q  <= {{LEVEL_BITS{1'b0}}, level};
									wr_ph_q <= PH_GREEN;
								end
							endcase
						end
					endcase
				end
				CMD_READ: begin
					if (port_in == PORT_DATA) begin
						if (rd_ph_eff == PH_BLUE) begin
							rd_ptr_q <= rd_ptr_q + 8'd1;
							rd_ph_q  <= PH_RED;
						end else if (rd_ph_eff == PH_GREEN) begin
							rd_ph_q <= PH_BLUE;
						end else begin
							rd_ph_q <= PH_GREEN;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_s1  <= cmd_in;
			port_s1 <= port_in;
			ph_s1   <= rd_ph_eff;
			unique case (port_in)
				PORT_MASK: pre_s1 <= mask_q;
				PORT_RIDX: pre_s1 <= rd_ptr_q;
				PORT_WIDX: pre_s1 <= wr_ptr_q;
				default:   pre_s1 <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			case (cmd_s1)
				CMD_READ: begin
					if (port_s1 == PORT_DATA) begin
						read_data <= 8'(entry_level(ram_rdata, ph_s1));
					end else begin
						read_data <= pre_s1;
					end
					red   <= '0;
					green <= '0;
					blue  <= '0;
				end
				CMD_LOOKUP: begin
					read_data <= '0;
					red       <= OUT_BITS'(entry_level(ram_rdata, PH_RED));
					green     <= OUT_BITS'(entry_level(ram_rdata, PH_GREEN));
					blue      <= OUT_BITS'(entry_level(ram_rdata, PH_BLUE));
				end
				default: begin
					read_data <= '0;
					red       <= '0;
					green     <= '0;
					blue      <= '0;
				end
			endcase
		end
	end

endmodule

// File: src/vga_dac_palette_top.sv
// VGA colour DAC palette.
// Input stream (s_*): one transfer per bus access or pixel lookup.
//   s_tuser selects the operation: write, read or lookup, and the bus port
//   (pixel mask, read index, write index, data). s_tdata carries the write
//   value or the pixel index.
// Output stream (m_*): exactly one transfer per input transfer, in order,
//   carrying the bus read value and the red, green, blue levels.
// The input transfer starts the fetch state, and the output register is loaded
//   from the fetch state. No new input is taken in the fetch state; the
//   registered read of the palette RAM sets the fetch state.
// Reset clears pointers and phases, sets the pixel mask to all ones and
//   empties the output register; palette contents stay undefined until written.
// When the receiver stalls the result holds in the output register and
//   s_tready stays low until it is taken.
module vga_dac_palette_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data[7:0]
	input  logic [3:0]  s_tuser,  // command[1:0], port[3:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // read_data[7:0], red[13:8], green[19:14], blue[25:20]
);
	import vdp_pkg::*;

	ctl_t ctl;
	logic [7:0]          read_data;
	logic [OUT_BITS-1:0] red, green, blue;

	vdp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.ctl     (ctl)
	);

	vdp_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.command  (s_tuser[1:0]),
		.port     (s_tuser[3:2]),
		.data     (s_tdata),
		.read_data(read_data),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	assign m_tdata = {6'd0, blue, green, red, read_data};

endmodule

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import vdp_pkg::*;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int ITEM_TARGET = 450;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] rd;
		logic [5:0] red;
		logic [5:0] green;
		logic [5:0] blue;
	} dac_out_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] port;
		logic [7:0] data;
		logic       known;
		dac_out_t   want;
	} step_t;

	localparam step_t PLAN [27] = '{
		'{CMD_READ,   PORT_MASK, 8'h00, 1'b1, '{8'hFF, 6'd0,  6'd0,  6'd0}},
		'{CMD_READ,   PORT_RIDX, 8'h00, 1'b1, '0},
		'{CMD_READ,   PORT_WIDX, 8'h5A, 1'b1, '0},
		'{CMD_WRITE,  PORT_WIDX, 8'h00, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'hFF, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h00, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'hC0, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h2A, 1'b0, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h15, 1'b0, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h3F, 1'b0, '0},
		'{CMD_WRITE,  PORT_WIDX, 8'hFF, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h3F, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h3F, 1'b1, '0},
		'{CMD_WRITE,  PORT_DATA, 8'h3F, 1'b1, '0},
		'{CMD_READ,   PORT_WIDX, 8'h00, 1'b1, '0},
		'{CMD_WRITE,  PORT_RIDX, 8'hFF, 1'b1, '0},
		'{CMD_READ,   PORT_DATA, 8'h00, 1'b1, '{8'h3F, 6'd0,  6'd0,  6'd0}},
		'{CMD_READ,   PORT_DATA, 8'h00, 1'b1, '{8'h3F, 6'd0,  6'd0,  6'd0}},
		'{CMD_READ,   PORT_DATA, 8'h00, 1'b1, '{8'h3F, 6'd0,  6'd0,  6'd0}},
		'{CMD_READ,   PORT_RIDX, 8'h00, 1'b1, '0},
		'{CMD_READ,   PORT_DATA, 8'h00, 1'b1, '{8'h3F, 6'd0,  6'd0,  6'd0}},
		'{CMD_LOOKUP, PORT_DATA, 8'hFF, 1'b1, '{8'h00, 6'd63, 6'd63, 6'd63}},
		'{CMD_WRITE,  PORT_MASK, 8'h01, 1'b1, '0},
		'{CMD_LOOKUP, PORT_DATA, 8'hFE, 1'b1, '{8'h00, 6'd63, 6'd0,  6'd0}},
		'{CMD_LOOKUP, PORT_DATA, 8'h01, 1'b0, '0},
		'{CMD_NONE,   PORT_DATA, 8'hFF, 1'b1, '0},
		'{CMD_WRITE,  PORT_MASK, 8'hFF, 1'b1, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [3:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	logic [ENTRY_BITS-1:0] palette [ENTRY_COUNT];
	bit                    entry_set [ENTRY_COUNT];
	int                    set_entries [$];
	logic [7:0]            wptr;
	logic [7:0]            rptr;
	logic [7:0]            pmask;
	logic [1:0]            wphase;
	logic [1:0]            rphase;
	logic [PEND_BITS-1:0]  pend_rg;

	dac_out_t colours_due [$];
	int       fails = 0;
	int       items = 0;
	int       cycles = 0;
	bit       steady_in = 1'b0;
	bit       steady_out = 1'b0;

	vga_dac_palette_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit touches_unwritten(input logic [1:0] cmd, input logic [1:0] port,
			input logic [7:0] data);
		if (cmd == CMD_READ && port == PORT_DATA)
			return !entry_set[rptr];
		if (cmd == CMD_LOOKUP)
			return !entry_set[data & pmask];
		return 1'b0;
	endfunction

	function automatic dac_out_t dac_predict(input logic [1:0] cmd, input logic [1:0] port,
			input logic [7:0] data);
		dac_out_t              res;
		logic [LEVEL_BITS-1:0] lvl;
		logic [ENTRY_BITS-1:0] ent;
		logic [1:0]            ph;
		res = '0;
		lvl = data[LEVEL_BITS-1:0];
		case (cmd)
			CMD_WRITE: begin
				case (port)
					PORT_MASK: pmask = data;
					PORT_RIDX: begin
						rptr = data;
						rphase = 2'd0;
					end
					PORT_WIDX: begin
						wptr = data;
						wphase = 2'd0;
					end
					default: begin
						if (wphase == 2'd1) begin
							pend_rg = {pend_rg[LEVEL_BITS-1:0], lvl};
							wphase = 2'd2;
						end else if (wphase == 2'd2) begin
							palette[wptr] = {pend_rg, lvl};
							if (!entry_set[wptr]) begin
								entry_set[wptr] = 1'b1;
								set_entries.push_back(wptr);
							end
							wptr = wptr + 8'd1;
							wphase = 2'd0;
						end else begin
							pend_rg = {{LEVEL_BITS{1'b0}}, lvl};
							wphase = 2'd1;
						end
					end
				endcase
			end
			CMD_READ: begin
				case (port)
					PORT_MASK: res.rd = pmask;
					PORT_RIDX: res.rd = rptr;
					PORT_WIDX: res.rd = wptr;
					default: begin
						ph = (rphase == 2'd3) ? 2'd0 : rphase;
						ent = palette[rptr];
						res.rd = 8'(ent[ENTRY_BITS-1 - ph*LEVEL_BITS -: LEVEL_BITS]);
						if (ph == 2'd2) begin
							rptr = rptr + 8'd1;
							rphase = 2'd0;
						end else begin
							rphase = ph + 2'd1;
						end
					end
				endcase
			end
			CMD_LOOKUP: begin
				ent = palette[data & pmask];
				res.red   = ent[3*LEVEL_BITS-1 -: 6];
				res.green = ent[2*LEVEL_BITS-1 -: 6];
				res.blue  = ent[LEVEL_BITS-1 -: 6];
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [7:0] pick_pixel();
		int         k;
		logic [7:0] noise;
		k = set_entries[$urandom_range(0, set_entries.size() - 1)];
		for (int t = 0; t < 8 && (8'(k) & ~pmask) != 8'd0; t++)
			k = set_entries[$urandom_range(0, set_entries.size() - 1)];
		if ((8'(k) & ~pmask) != 8'd0)
			k = 0;
		noise = 8'($urandom);
		return 8'(k) | (noise & ~pmask);
	endfunction

	task automatic drive_item(input logic [1:0] cmd, input logic [1:0] port,
			input logic [7:0] data);
		int gap;
		if ($urandom_range(0, 39) == 0)
			steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {port, cmd};
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic issue(input logic [1:0] cmd, input logic [1:0] port, input logic [7:0] data);
		if (touches_unwritten(cmd, port, data))
			return;
		colours_due.push_back(dac_predict(cmd, port, data));
		if (cmd != CMD_NONE)
			items++;
		drive_item(cmd, port, data);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	initial begin
		dac_out_t want;
		int       k;
		int       n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'd0;
		s_tuser  = 4'd0;
		wptr     = 8'd0;
		rptr     = 8'd0;
		wphase   = 2'd0;
		rphase   = 2'd0;
		pend_rg  = '0;
		pmask    = MASK_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			want = dac_predict(PLAN[i].cmd, PLAN[i].port, PLAN[i].data);
			if (PLAN[i].known)
				want = PLAN[i].want;
			colours_due.push_back(want);
			drive_item(PLAN[i].cmd, PLAN[i].port, PLAN[i].data);
		end

		while (items < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					issue(CMD_WRITE, PORT_WIDX, 8'($urandom));
					n = ($urandom_range(0, 3) == 0) ? 6 : 3;
					repeat (n) issue(CMD_WRITE, PORT_DATA, 8'($urandom));
				end
				3, 4: begin
					k = set_entries[$urandom_range(0, set_entries.size() - 1)];
					issue(CMD_READ, PORT_RIDX, 8'(k));
					n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 3;
					repeat (n) issue(CMD_READ, PORT_DATA, 8'($urandom));
				end
				5, 6: repeat ($urandom_range(1, 4))
					issue(CMD_LOOKUP, 2'($urandom), pick_pixel());
				7: repeat ($urandom_range(1, 3))
					issue(2'($urandom), 2'($urandom), 8'($urandom));
				8: begin
					issue(CMD_WRITE, PORT_MASK, $urandom_range(0, 1) ? 8'($urandom) : 8'hFF);
					issue(CMD_READ, PORT_MASK, 8'($urandom));
				end
				default: begin
					if ($urandom_range(0, 1)) begin
						issue(CMD_WRITE, PORT_WIDX, 8'($urandom));
						repeat ($urandom_range(1, 2))
							issue(CMD_WRITE, PORT_DATA, 8'($urandom));
					end else begin
						k = set_entries[$urandom_range(0, set_entries.size() - 1)];
						issue(CMD_READ, PORT_RIDX, 8'(k));
						repeat ($urandom_range(1, 2))
							issue(CMD_READ, PORT_DATA, 8'($urandom));
					end
				end
			endcase
		end
		s_tvalid <= 1'b0;

		while (colours_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("[vga_dac_palette_top] OK");
		else
			$display("[vga_dac_palette_top] ERROR");
		$finish;
	end

	initial begin
		int gap;
		m_tready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady_out = !steady_out;
			gap = steady_out ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		dac_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (colours_due.size() == 0) begin
				$error("transfer out with nothing outstanding: %h", m_tdata);
				fails++;
			end else begin
				want = colours_due.pop_front();
				check_field("read_data", want.rd,    m_tdata[7:0]);
				check_field("red",       want.red,   m_tdata[13:8]);
				check_field("green",     want.green, m_tdata[19:14]);
				check_field("blue",      want.blue,  m_tdata[25:20]);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[vga_dac_palette_top] ERROR");
			$finish;
		end
	end

endmodule
